// ===== design/afk_pkg.sv =====
// ----------------------------------------------------------------------------
// afk_pkg: shared types and constants for the arm forward kinematics block
// Beat formats, fixed-point constants and the rounding multiply used by
// the sine/cosine pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

  localparam int ANGLE_WIDTH     = 16;
  localparam int NUM_JOINTS      = 6;
  localparam int CFG_WIDTH       = 24;
  localparam int CFG_ADDR_WIDTH  = 5;
  localparam int APB_DATA_WIDTH  = 32;
  localparam int LEN_WIDTH       = CFG_WIDTH + 4;   // Q24 link lengths
  localparam int POS_ACC_WIDTH   = 34;              // Q24 running position
  localparam int POS_WIDTH       = 24;
  localparam int ROT_WIDTH       = 16;
  localparam int SC_STAGES       = 13;
  localparam int COS_STEPS       = 5;
  localparam int SIN_STEPS       = 4;

  typedef logic signed [31:0] afk_q30_t;
  typedef logic signed [ANGLE_WIDTH-1:0] afk_angle_t;
  typedef logic signed [POS_ACC_WIDTH-1:0] afk_pos_t;
  typedef logic signed [LEN_WIDTH-1:0] afk_len_t;

  localparam afk_q30_t Q30_ONE = 32'sh4000_0000;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  // floor(x / k) == (x * M) >> SH for 0 <= x < 2^30
  localparam logic [31:0] COS_M [COS_STEPS] = '{
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam int COS_SH [COS_STEPS] = '{37, 36, 35, 34, 31};

  localparam logic [31:0] SIN_M [SIN_STEPS] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SH [SIN_STEPS] = '{37, 36, 35, 33};

  typedef enum logic [1:0] {
    ALPHA_ZERO,
    ALPHA_POS90,
    ALPHA_NEG90
  } afk_alpha_t;

  localparam afk_alpha_t CELL_ALPHA [NUM_JOINTS] = '{
    ALPHA_ZERO, ALPHA_POS90, ALPHA_ZERO, ALPHA_ZERO, ALPHA_POS90, ALPHA_NEG90
  };

  typedef enum logic [2:0] {
    REG_LINK_A2   = 3'd0,
    REG_LINK_A3   = 3'd1,
    REG_OFFSET_D1 = 3'd2,
    REG_OFFSET_D3 = 3'd3,
    REG_OFFSET_D4 = 3'd4,
    REG_OFFSET_D5 = 3'd5,
    REG_OFFSET_D6 = 3'd6
  } afk_reg_t;

  typedef struct packed {
    afk_angle_t joint1_angle;
    afk_angle_t joint2_angle;
    afk_angle_t joint3_angle;
    afk_angle_t joint4_angle;
    afk_angle_t joint5_angle;
    afk_angle_t joint6_angle;
  } afk_in_t;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [ROT_WIDTH-1:0] rot_00;
    logic signed [ROT_WIDTH-1:0] rot_01;
    logic signed [ROT_WIDTH-1:0] rot_02;
    logic signed [ROT_WIDTH-1:0] rot_10;
    logic signed [ROT_WIDTH-1:0] rot_11;
    logic signed [ROT_WIDTH-1:0] rot_12;
    logic signed [ROT_WIDTH-1:0] rot_20;
    logic signed [ROT_WIDTH-1:0] rot_21;
    logic signed [ROT_WIDTH-1:0] rot_22;
  } afk_out_t;

  typedef struct packed {
    afk_q30_t sn;
    afk_q30_t cs;
  } afk_sc_t;

  // frame plus the sine/cosine pairs still to be consumed (next one in sc[0])
  typedef struct packed {
    afk_q30_t [8:0]            rot;
    afk_pos_t [2:0]            pos;
    afk_sc_t [NUM_JOINTS-1:0]  sc;
  } afk_beat_t;

  // round(a * b / 2^30), half up
  function automatic afk_q30_t mul30(input afk_q30_t a, input afk_q30_t b);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = 64'(a) * 64'(b);
    rnd  = (prod + 64'sd536870912) >>> 30;
    return rnd[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/afk_sincos.sv =====
// ----------------------------------------------------------------------------
// afk_sincos: pipelined sine/cosine of one joint angle
// Quadrant reduction, then Horner steps of a multiply and a constant divide,
// one operation per stage. Result in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_sincos (
  input  logic                 clk,
  input  logic                 en,
  input  afk_pkg::afk_angle_t  angle,
  output afk_pkg::afk_sc_t     sc
);

  localparam int NSTAGE   = 2 * afk_pkg::COS_STEPS + 1;
  localparam int RED_SPAN = 3;
  localparam int NCAND    = 2 * RED_SPAN + 1;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    afk_pkg::afk_q30_t s;
    afk_pkg::afk_q30_t c;
    afk_pkg::afk_q30_t r2;
    logic signed [30:0] rr;
    logic [1:0]         quad;
  } sc_stage_t;

  logic signed [33:0] r_full;
  logic signed [35:0] cand [NCAND];
  logic signed [36:0] twice [NCAND];
  logic signed [30:0] red_rr;
  logic [1:0]         red_quad;
  logic signed [30:0] s1_rr_r;
  logic [1:0]         s1_quad_r;
  sc_stage_t          st_nxt [NSTAGE];
  sc_stage_t          st_r [NSTAGE];
  afk_pkg::afk_sc_t   sc_r;

  // pick the multiple of pi/2 that leaves 2*r within [-P, P]
  always_comb begin
    r_full   = 34'(angle) <<< (33 - afk_pkg::ANGLE_WIDTH);
    red_rr   = r_full[30:0];
    red_quad = QUAD_0;
    for (int j = 0; j < NCAND; j++) begin
      cand[j]  = 36'(r_full) - 36'(j - RED_SPAN) * afk_pkg::HALF_PI_Q30;
      twice[j] = 37'(cand[j]) <<< 1;
      if ((twice[j] >= -37'(afk_pkg::HALF_PI_Q30)) &&
          (twice[j] <= 37'(afk_pkg::HALF_PI_Q30))) begin
        red_rr   = cand[j][30:0];
        red_quad = 2'(j + 1);
      end
    end
  end

  always_comb begin
    st_nxt[0].s    = afk_pkg::Q30_ONE;
    st_nxt[0].c    = afk_pkg::Q30_ONE;
    st_nxt[0].r2   = afk_pkg::mul30(32'(s1_rr_r), 32'(s1_rr_r));
    st_nxt[0].rr   = s1_rr_r;
    st_nxt[0].quad = s1_quad_r;
  end

  for (genvar i = 0; i < afk_pkg::COS_STEPS; i++) begin : gen_step
    sc_stage_t   a_nxt;
    sc_stage_t   b_nxt;
    logic [63:0] cprod;
    logic [63:0] cquo;

    always_comb begin
      a_nxt   = st_r[2*i];
      a_nxt.c = afk_pkg::mul30(st_r[2*i].r2, st_r[2*i].c);
      if (i < afk_pkg::SIN_STEPS) begin
        a_nxt.s = afk_pkg::mul30(st_r[2*i].r2, st_r[2*i].s);
      end else begin
        a_nxt.s = afk_pkg::mul30(32'(st_r[2*i].rr), st_r[2*i].s);
      end
    end

    always_comb begin
      b_nxt   = st_r[2*i+1];
      cprod   = 64'(st_r[2*i+1].c[30:0]) * 64'(afk_pkg::COS_M[i]);
      cquo    = cprod >> afk_pkg::COS_SH[i];
      b_nxt.c = afk_pkg::Q30_ONE - afk_pkg::afk_q30_t'(cquo[31:0]);
    end

    if (i < afk_pkg::SIN_STEPS) begin : gen_sin
      logic [63:0]       sprod;
      logic [63:0]       squo;
      afk_pkg::afk_q30_t s_new;
      always_comb begin
        sprod = 64'(st_r[2*i+1].s[30:0]) * 64'(afk_pkg::SIN_M[i]);
        squo  = sprod >> afk_pkg::SIN_SH[i];
        s_new = afk_pkg::Q30_ONE - afk_pkg::afk_q30_t'(squo[31:0]);
      end
      assign st_nxt[2*i+2] = '{s: s_new, c: b_nxt.c, r2: b_nxt.r2,
                               rr: b_nxt.rr, quad: b_nxt.quad};
    end else begin : gen_hold
      assign st_nxt[2*i+2] = b_nxt;
    end

    assign st_nxt[2*i+1] = a_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rr_r   <= red_rr;
      s1_quad_r <= red_quad;
      st_r      <= st_nxt;
      case (st_r[NSTAGE-1].quad)
        QUAD_0: begin
          sc_r.sn <= st_r[NSTAGE-1].s;
          sc_r.cs <= st_r[NSTAGE-1].c;
        end
        QUAD_1: begin
          sc_r.sn <= st_r[NSTAGE-1].c;
          sc_r.cs <= -st_r[NSTAGE-1].s;
        end
        QUAD_2: begin
          sc_r.sn <= -st_r[NSTAGE-1].s;
          sc_r.cs <= -st_r[NSTAGE-1].c;
        end
        default: begin
          sc_r.sn <= -st_r[NSTAGE-1].c;
          sc_r.cs <= st_r[NSTAGE-1].s;
        end
      endcase
    end
  end

  assign sc = sc_r;

endmodule

`default_nettype wire

// ===== design/afk_link_cell.sv =====
// ----------------------------------------------------------------------------
// afk_link_cell: one link of the kinematic chain
// Applies Rx(alpha) Tx(a) Tz(d) Rz(theta) to the running frame in two
// stages: registered products, then three-term sums with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_link_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  afk_pkg::afk_alpha_t  alpha,
  input  afk_pkg::afk_len_t    link_a,
  input  afk_pkg::afk_len_t    link_d,
  input  logic                 in_vld,
  input  afk_pkg::afk_beat_t   in_beat,
  output logic                 out_vld,
  output afk_pkg::afk_beat_t   out_beat
);

  afk_pkg::afk_q30_t lr [9];
  logic signed [28:0] lp [3];
  logic signed [63:0] rprod_r [27];
  logic signed [63:0] pprod_r [9];
  afk_pkg::afk_pos_t [2:0] pos_a_r;
  afk_pkg::afk_sc_t [afk_pkg::NUM_JOINTS-1:0] sc_a_r;
  logic               vld_a_r;
  logic               vld_b_r;
  afk_pkg::afk_beat_t beat_nxt;
  afk_pkg::afk_beat_t beat_r;

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      lr[n] = '0;
    end
    lr[0] = in_beat.sc[0].cs;
    lr[1] = -in_beat.sc[0].sn;
    lp[0] = 29'(link_a);
    unique case (alpha)
      afk_pkg::ALPHA_POS90: begin
        lr[5] = -afk_pkg::Q30_ONE;
        lr[6] = in_beat.sc[0].sn;
        lr[7] = in_beat.sc[0].cs;
        lp[1] = -29'(link_d);
        lp[2] = '0;
      end
      afk_pkg::ALPHA_NEG90: begin
        lr[5] = afk_pkg::Q30_ONE;
        lr[6] = -in_beat.sc[0].sn;
        lr[7] = -in_beat.sc[0].cs;
        lp[1] = 29'(link_d);
        lp[2] = '0;
      end
      default: begin
        lr[3] = in_beat.sc[0].sn;
        lr[4] = in_beat.sc[0].cs;
        lr[8] = afk_pkg::Q30_ONE;
        lp[1] = '0;
        lp[2] = 29'(link_d);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pprod_r[i*3+k] <= 64'($signed(in_beat.rot[i*3+k])) * 64'(lp[k]);
          for (int j = 0; j < 3; j++) begin
            rprod_r[(i*3+j)*3+k] <= 64'($signed(in_beat.rot[i*3+k])) * 64'(lr[k*3+j]);
          end
        end
      end
      pos_a_r <= in_beat.pos;
      // hand the remaining angle pairs down by one joint
      sc_a_r  <= in_beat.sc >> $bits(afk_pkg::afk_sc_t);
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    logic signed [63:0] rnd;
    for (int i = 0; i < 3; i++) begin
      acc = pprod_r[i*3] + pprod_r[i*3+1] + pprod_r[i*3+2];
      rnd = (acc + 64'sd536870912) >>> 30;
      beat_nxt.pos[i] = pos_a_r[i] + afk_pkg::afk_pos_t'(rnd[afk_pkg::POS_ACC_WIDTH-1:0]);
      for (int j = 0; j < 3; j++) begin
        acc = rprod_r[(i*3+j)*3] + rprod_r[(i*3+j)*3+1] + rprod_r[(i*3+j)*3+2];
        rnd = (acc + 64'sd536870912) >>> 30;
        beat_nxt.rot[i*3+j] = rnd[31:0];
      end
    end
    beat_nxt.sc = sc_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_vld  = vld_b_r;
  assign out_beat = beat_r;

endmodule

`default_nettype wire

// ===== design/arm_forward_kinematics_6dof_top.sv =====
// ----------------------------------------------------------------------------
// arm_forward_kinematics_6dof_top: six-joint arm forward kinematics
// Six joint angles in, end position and 3x3 end rotation out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries six joint angles (radians, signed Q3.13).
//   out_* : one beat per input beat: position (Q4.20 m, saturated) and
//           rotation (Q2.14), in input order.
//   APB   : seven link length registers at byte addresses 0, 4, .. 24,
//           Q4.20 m; write only while no beat is in flight.
// A beat passes the sine/cosine pipeline for all six joints in parallel,
// then the six link cells in turn, then the output register. One beat is
// taken per cycle while in_stall is low.
// When out_stall holds a result, one more result lands in a skid register;
// after that in_stall rises and the whole pipeline freezes until the held
// result is taken. in_stall is registered.
// Reset clears all valid flags, the skid state and the link registers.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_forward_kinematics_6dof_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  afk_pkg::afk_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output afk_pkg::afk_out_t                      out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [afk_pkg::CFG_ADDR_WIDTH-1:0]     paddr,
  input  logic [afk_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [afk_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                   pready
);

  localparam int NJ = afk_pkg::NUM_JOINTS;

  logic signed [afk_pkg::CFG_WIDTH-1:0] link_a2_r, link_a3_r;
  logic signed [afk_pkg::CFG_WIDTH-1:0] offset_d1_r, offset_d3_r, offset_d4_r;
  logic signed [afk_pkg::CFG_WIDTH-1:0] offset_d5_r, offset_d6_r;
  afk_pkg::afk_reg_t reg_idx;

  logic                        en;
  logic [afk_pkg::SC_STAGES-1:0] sv_r;
  afk_pkg::afk_angle_t         ang [NJ];
  afk_pkg::afk_sc_t [NJ-1:0]   sc_all;
  afk_pkg::afk_len_t           cell_a [NJ];
  afk_pkg::afk_len_t           cell_d [NJ];
  afk_pkg::afk_beat_t          cell_beat [NJ+1];
  logic                        cell_vld [NJ+1];
  logic                        produce;
  logic                        out_free;
  afk_pkg::afk_out_t           res;
  logic                        out_valid_r, skid_valid_r;
  afk_pkg::afk_out_t           out_data_r, skid_data_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = afk_pkg::afk_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_a2_r   <= '0;
      link_a3_r   <= '0;
      offset_d1_r <= '0;
      offset_d3_r <= '0;
      offset_d4_r <= '0;
      offset_d5_r <= '0;
      offset_d6_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        afk_pkg::REG_LINK_A2:   link_a2_r   <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_LINK_A3:   link_a3_r   <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_OFFSET_D1: offset_d1_r <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_OFFSET_D3: offset_d3_r <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_OFFSET_D4: offset_d4_r <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_OFFSET_D5: offset_d5_r <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        afk_pkg::REG_OFFSET_D6: offset_d6_r <= pwdata[afk_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      afk_pkg::REG_LINK_A2:   prdata = 32'(link_a2_r);
      afk_pkg::REG_LINK_A3:   prdata = 32'(link_a3_r);
      afk_pkg::REG_OFFSET_D1: prdata = 32'(offset_d1_r);
      afk_pkg::REG_OFFSET_D3: prdata = 32'(offset_d3_r);
      afk_pkg::REG_OFFSET_D4: prdata = 32'(offset_d4_r);
      afk_pkg::REG_OFFSET_D5: prdata = 32'(offset_d5_r);
      afk_pkg::REG_OFFSET_D6: prdata = 32'(offset_d6_r);
      default:                prdata = '0;
    endcase
  end

  // Q4.20 register -> Q24 link length
  function automatic afk_pkg::afk_len_t to_q24(input logic signed [afk_pkg::CFG_WIDTH-1:0] v);
    return afk_pkg::afk_len_t'({v, 4'b0000});
  endfunction

  always_comb begin
    cell_a[0] = '0;                  cell_d[0] = to_q24(offset_d1_r);
    cell_a[1] = '0;                  cell_d[1] = '0;
    cell_a[2] = to_q24(link_a2_r);   cell_d[2] = to_q24(offset_d3_r);
    cell_a[3] = to_q24(link_a3_r);   cell_d[3] = to_q24(offset_d4_r);
    cell_a[4] = '0;                  cell_d[4] = to_q24(offset_d5_r);
    cell_a[5] = '0;                  cell_d[5] = to_q24(offset_d6_r);
  end

  // ---------------- sine / cosine front ----------------
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign ang[0] = in_data.joint1_angle;
  assign ang[1] = in_data.joint2_angle;
  assign ang[2] = in_data.joint3_angle;
  assign ang[3] = in_data.joint4_angle;
  assign ang[4] = in_data.joint5_angle;
  assign ang[5] = in_data.joint6_angle;

  for (genvar g = 0; g < NJ; g++) begin : gen_sc
    afk_sincos u_sc (
      .clk   (clk),
      .en    (en),
      .angle (ang[g]),
      .sc    (sc_all[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= {sv_r[afk_pkg::SC_STAGES-2:0], in_valid};
    end
  end

  // ---------------- link cell chain ----------------
  always_comb begin
    cell_beat[0].rot = '0;
    cell_beat[0].rot[0] = afk_pkg::Q30_ONE;
    cell_beat[0].rot[4] = afk_pkg::Q30_ONE;
    cell_beat[0].rot[8] = afk_pkg::Q30_ONE;
    cell_beat[0].pos = '0;
    cell_beat[0].sc  = sc_all;
  end
  assign cell_vld[0] = sv_r[afk_pkg::SC_STAGES-1];

  for (genvar g = 0; g < NJ; g++) begin : gen_cell
    afk_link_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .alpha    (afk_pkg::CELL_ALPHA[g]),
      .link_a   (cell_a[g]),
      .link_d   (cell_d[g]),
      .in_vld   (cell_vld[g]),
      .in_beat  (cell_beat[g]),
      .out_vld  (cell_vld[g+1]),
      .out_beat (cell_beat[g+1])
    );
  end

  // ---------------- output rounding and saturation ----------------
  function automatic logic signed [afk_pkg::POS_WIDTH-1:0] pos_out(input afk_pkg::afk_pos_t p);
    logic signed [afk_pkg::POS_ACC_WIDTH:0] t;
    t = (35'(p) + 35'sd8) >>> 4;
    if (t > 35'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (t < -35'sd8388608) begin
      return 24'sh800000;
    end
    return t[afk_pkg::POS_WIDTH-1:0];
  endfunction

  function automatic logic signed [afk_pkg::ROT_WIDTH-1:0] rot_out(input afk_pkg::afk_q30_t r);
    logic signed [32:0] t;
    t = (33'(r) + 33'sd32768) >>> 16;
    if (t > 33'sd32767) begin
      return 16'sh7FFF;
    end else if (t < -33'sd32768) begin
      return 16'sh8000;
    end
    return t[afk_pkg::ROT_WIDTH-1:0];
  endfunction

  always_comb begin
    res.pos_x  = pos_out(cell_beat[NJ].pos[0]);
    res.pos_y  = pos_out(cell_beat[NJ].pos[1]);
    res.pos_z  = pos_out(cell_beat[NJ].pos[2]);
    res.rot_00 = rot_out(cell_beat[NJ].rot[0]);
    res.rot_01 = rot_out(cell_beat[NJ].rot[1]);
    res.rot_02 = rot_out(cell_beat[NJ].rot[2]);
    res.rot_10 = rot_out(cell_beat[NJ].rot[3]);
    res.rot_11 = rot_out(cell_beat[NJ].rot[4]);
    res.rot_12 = rot_out(cell_beat[NJ].rot[5]);
    res.rot_20 = rot_out(cell_beat[NJ].rot[6]);
    res.rot_21 = rot_out(cell_beat[NJ].rot[7]);
    res.rot_22 = rot_out(cell_beat[NJ].rot[8]);
  end

  // ---------------- output register with skid ----------------
  assign produce  = en && cell_vld[NJ];
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= produce;
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (produce) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/afk_checker.sv =====
// ----------------------------------------------------------------------------
// afk_checker: port-level checks for the forward kinematics block
// Output hold under stall, skid behavior of in_stall, reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input afk_pkg::afk_out_t out_data
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out beat changed under stall");

  // input side only stalls while a result is parked at the output
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending out beat");

  // skid fills only after the output was held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output stall");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind arm_forward_kinematics_6dof_top afk_checker u_afk_checker (.*);

`default_nettype wire
